FILE: rtl/core/rtp_seq_extend_jitter_top_defines.svh
// ----------------------------------------------------------------------------
// RTP sequence extension and jitter block: assertion macros
// Assertion wrappers that compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RTP_SEQ_EXTEND_JITTER_TOP_DEFINES_SVH
`define RTP_SEQ_EXTEND_JITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RSJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RSJ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSJ_ASSERT(label, prop, msg)
`define RSJ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/core/rsj_pkg.sv
// ----------------------------------------------------------------------------
// RTP sequence extension and jitter package
// Widths, constants and the pipeline stage type shared by the block.
// ----------------------------------------------------------------------------
package rsj_pkg;

  localparam int SEQ_W      = 16;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 40;
  localparam int ABS_W      = 51;
  localparam int SDATA_W    = 80;
  localparam int MDATA_W    = 128;
  localparam int MUSER_W    = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WORD_W-1:0] CYCLE_STEP    = 32'h0001_0000;
  localparam logic [WORD_W-1:0] TS_WRAP_LIMIT = 32'h1000_0000;
  localparam logic [ABS_W-1:0]  T1_LIMIT      = 51'h2_0000_0000_0000;
  localparam logic [ACC_W-1:0]  ACC_MAX       = 40'hFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] COUNT_MAX     = 32'hFFFF_FFFF;

  // Register index bit of the byte address; index 0 holds the rate.
  localparam int          CFG_INDEX_BIT = 2;
  localparam logic        CFG_IDX_RATE  = 1'b0;

  typedef struct packed {
    logic [WORD_W-1:0] ext_seq;
    logic [WORD_W-1:0] high_seq;
    logic [WORD_W-1:0] pkt_count;
    logic              first;
    logic              sub;
    logic              ts_neg;
    logic [WORD_W-1:0] ts_mag;
    logic [PROD_W-1:0] prod;
  } stage_t;

endpackage

FILE: rtl/core/rtp_seq_extend_jitter_top.sv
// ----------------------------------------------------------------------------
// RTP sequence extension and interarrival jitter
// Each item is registered in stage one and then in the output register; one
// item per cycle while the result sink is ready.
// Stage one extends the sequence number and multiplies the arrival spacing by
// the rate; stage two updates the jitter accumulator, which feeds back on itself.
// Synchronous reset clears all statistics and sets the rate register to zero.
// ----------------------------------------------------------------------------
`include "rtp_seq_extend_jitter_top_defines.svh"

module rtp_seq_extend_jitter_top #(
  parameter int JITTER_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // tdata: seq_number[15:0], media_timestamp[47:16], arrival_ticks[79:48]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rsj_pkg::SDATA_W-1:0]      s_axis_tdata,
  // tuser: subflow_select
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: extended_seq[31:0], highest_ext_seq[63:32], jitter_units[95:64],
  //        packet_count[127:96]
  output logic [rsj_pkg::MDATA_W-1:0]      m_axis_tdata,
  // tuser: first_packet[0], subflow_tag[1]
  output logic [rsj_pkg::MUSER_W-1:0]      m_axis_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rsj_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rsj_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rsj_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  import rsj_pkg::*;

  localparam int SHIFT = 16 - JITTER_FRAC_BITS;

  logic [WORD_W-1:0] time_to_ts_rate;
  logic              seen_any;
  logic [WORD_W-1:0] high_ext_seq;
  logic [WORD_W-1:0] wrap_cycles;
  logic [WORD_W-1:0] prev_arrival;
  logic [WORD_W-1:0] prev_media_ts;
  logic [ACC_W-1:0]  jitter_acc;
  logic [WORD_W-1:0] pkt_total;

  logic              s1_valid;
  stage_t            s1;
  logic              out_valid;
  logic [MDATA_W-1:0] out_data;
  logic [MUSER_W-1:0] out_user;

  logic in_acc;
  logic adv;
  logic cfg_wr;

  // Stage one signals.
  logic [SEQ_W-1:0]  seq;
  logic [WORD_W-1:0] ts;
  logic [WORD_W-1:0] arrival;
  logic [SEQ_W-1:0]  top16;
  logic [SEQ_W-1:0]  fwd;
  logic [SEQ_W-1:0]  bwd;
  logic [WORD_W-1:0] ext_seq;
  logic [WORD_W-1:0] high_ext_seq_next;
  logic [WORD_W-1:0] wrap_cycles_next;
  logic [WORD_W-1:0] pkt_total_next;
  logic [WORD_W-1:0] ts_diff;
  logic [WORD_W-1:0] ts_back;
  logic              ts_neg;
  logic [WORD_W-1:0] ts_mag;
  stage_t            s1_next;

  // Stage two signals.
  logic [PROD_W-1:0] t1;
  logic [ABS_W-1:0]  t1c;
  logic [ABS_W-1:0]  t2;
  logic [ABS_W-1:0]  t_sum;
  logic [ABS_W-1:0]  t_diff;
  logic [ABS_W-1:0]  absd_raw;
  logic [ACC_W-1:0]  absd;
  logic [ACC_W-1:0]  acc_up;
  logic [ACC_W:0]    down_round;
  logic [ACC_W-1:0]  acc_down;
  logic [ACC_W-1:0]  jitter_acc_next;
  logic [ACC_W-1:0]  ju_wide;
  logic [WORD_W-1:0] jitter_units;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv || !s1_valid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[CFG_INDEX_BIT] == CFG_IDX_RATE);
  assign prdata = (paddr[CFG_INDEX_BIT] == CFG_IDX_RATE) ? time_to_ts_rate : '0;

  assign seq     = s_axis_tdata[15:0];
  assign ts      = s_axis_tdata[47:16];
  assign arrival = s_axis_tdata[79:48];

  always_comb begin
    top16             = high_ext_seq[SEQ_W-1:0];
    fwd               = seq - top16;
    bwd               = top16 - seq;
    wrap_cycles_next  = wrap_cycles;
    high_ext_seq_next = high_ext_seq;
    if (!seen_any) begin
      if (seq == '0) begin
        wrap_cycles_next  = CYCLE_STEP;
        high_ext_seq_next = CYCLE_STEP;
      end else begin
        high_ext_seq_next = {{(WORD_W-SEQ_W){1'b0}}, seq};
      end
      ext_seq = high_ext_seq_next;
    end else if (seq >= top16) begin
      ext_seq           = wrap_cycles + {{(WORD_W-SEQ_W){1'b0}}, seq};
      high_ext_seq_next = ext_seq;
    end else if (fwd < bwd) begin
      wrap_cycles_next  = wrap_cycles + CYCLE_STEP;
      ext_seq           = wrap_cycles_next + {{(WORD_W-SEQ_W){1'b0}}, seq};
      high_ext_seq_next = ext_seq;
    end else begin
      ext_seq = wrap_cycles + {{(WORD_W-SEQ_W){1'b0}}, seq};
    end
    pkt_total_next = (pkt_total == COUNT_MAX) ? pkt_total : pkt_total + 1'b1;
  end

  always_comb begin
    ts_diff = ts - prev_media_ts;
    ts_back = prev_media_ts - ts;
    if (ts == prev_media_ts) begin
      ts_neg = 1'b0;
      ts_mag = '0;
    end else if (ts > prev_media_ts) begin
      ts_neg = !(ts_diff < TS_WRAP_LIMIT);
      ts_mag = ts_neg ? ts_back : ts_diff;
    end else begin
      ts_neg = ts_back < TS_WRAP_LIMIT;
      ts_mag = ts_neg ? ts_back : ts_diff;
    end
  end

  always_comb begin
    s1_next.ext_seq   = ext_seq;
    s1_next.high_seq  = high_ext_seq_next;
    s1_next.pkt_count = pkt_total_next;
    s1_next.first     = !seen_any;
    s1_next.sub       = s_axis_tuser;
    s1_next.ts_neg    = ts_neg;
    s1_next.ts_mag    = ts_mag;
    s1_next.prod      = {{(PROD_W-WORD_W){1'b0}}, arrival - prev_arrival}
                      * {{(PROD_W-WORD_W){1'b0}}, time_to_ts_rate};
  end

  // A spacing above the limit saturates the absolute difference either way.
  always_comb begin
    t1        = s1.prod >> SHIFT;
    t1c       = (t1 >= PROD_W'(T1_LIMIT)) ? T1_LIMIT : t1[ABS_W-1:0];
    t2        = ABS_W'(s1.ts_mag) << JITTER_FRAC_BITS;
    t_sum     = t1c + t2;
    t_diff    = (t1c >= t2) ? (t1c - t2) : (t2 - t1c);
    absd_raw  = s1.ts_neg ? t_sum : t_diff;
    absd      = (absd_raw > ABS_W'(ACC_MAX)) ? ACC_MAX : absd_raw[ACC_W-1:0];
    acc_up    = jitter_acc + ((absd - jitter_acc) >> 4);
    down_round = {1'b0, jitter_acc - absd} + (ACC_W+1)'(15);
    acc_down  = jitter_acc - down_round[ACC_W:4];
    if (s1.first) begin
      jitter_acc_next = jitter_acc;
    end else if (time_to_ts_rate == '0) begin
      jitter_acc_next = '0;
    end else if (absd >= jitter_acc) begin
      jitter_acc_next = acc_up;
    end else begin
      jitter_acc_next = acc_down;
    end
    ju_wide      = jitter_acc_next >> JITTER_FRAC_BITS;
    jitter_units = (|ju_wide[ACC_W-1:WORD_W]) ? COUNT_MAX : ju_wide[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_to_ts_rate <= '0;
      seen_any        <= 1'b0;
      high_ext_seq    <= '0;
      wrap_cycles     <= '0;
      prev_arrival    <= '0;
      prev_media_ts   <= '0;
      jitter_acc      <= '0;
      pkt_total       <= '0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        time_to_ts_rate <= pwdata;
      end
      if (in_acc) begin
        seen_any      <= 1'b1;
        high_ext_seq  <= high_ext_seq_next;
        wrap_cycles   <= wrap_cycles_next;
        prev_arrival  <= arrival;
        prev_media_ts <= ts;
        pkt_total     <= pkt_total_next;
      end
      if (adv && s1_valid) begin
        jitter_acc <= jitter_acc_next;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1 <= s1_next;
    end
    if (adv && s1_valid) begin
      out_data <= {s1.pkt_count, jitter_units, s1.high_seq, s1.ext_seq};
      out_user <= {s1.sub, s1.first};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

  `RSJ_ASSERT(a_count_tracks_seen, seen_any == (pkt_total != '0), "count and seen flag disagree")
  `RSJ_ASSERT(a_first_result, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:96] == 32'd1 && m_axis_tdata[31:0] == m_axis_tdata[63:32], "first result inconsistent")
  `RSJ_ASSERT(a_rate_zero_clears, adv && s1_valid && !s1.first && time_to_ts_rate == '0 |=> jitter_acc == '0, "jitter not cleared at zero rate")
  `RSJ_ASSERT(a_stall_blocks_input, s1_valid && !adv |-> !s_axis_tready, "input taken while pipeline full")

endmodule

FILE: sim/rtp_seq_extend_jitter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP sequence extension and jitter checker
// Watches the packet, result and register channels, keeps its own copy of the
// per-source statistics, and compares every result item with its prediction.
// ----------------------------------------------------------------------------
module rtp_seq_extend_jitter_checker #(
  parameter int JITTER_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [rsj_pkg::SDATA_W-1:0]    s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [rsj_pkg::MDATA_W-1:0]    m_axis_tdata,
  input  logic [rsj_pkg::MUSER_W-1:0]    m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsj_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rsj_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             error_count,
  output int                             pending
);

  localparam logic [rsj_pkg::CFG_ADDR_W-1:0] RATE_ADDR = {rsj_pkg::CFG_IDX_RATE, 2'b00};
  localparam logic [31:0] SEQ_STEP   = 32'h0001_0000;
  localparam logic [31:0] TS_LIMIT   = 32'h1000_0000;
  localparam logic [63:0] SPAN_CLAMP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] JIT_MAX    = 64'h0000_00FF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] ext_seq;
    logic [31:0] high_seq;
    logic [31:0] jitter;
    logic [31:0] count;
    logic        first;
    logic        sub;
  } pkt_stats_t;

  pkt_stats_t  stats_q[$];
  logic [31:0] rate;
  logic        seen_any;
  logic [31:0] high_seq;
  logic [31:0] wrap_base;
  logic [31:0] prev_arr;
  logic [31:0] prev_ts;
  logic [39:0] jitter_acc;
  logic [31:0] pkt_total;
  int          fail_total = 0;

  function automatic pkt_stats_t predict_stats(logic [15:0] seq, logic [31:0] ts,
                                               logic [31:0] arr, logic sub);
    pkt_stats_t  r;
    logic [31:0] seq32, top16, fwd, bwd, ext, dt, d, back, mag;
    logic [63:0] t1, t2, absd, acc64, jit;
    logic        neg;
    r = '0;
    seq32 = {16'd0, seq};
    if (pkt_total != 32'hFFFF_FFFF) pkt_total = pkt_total + 1;
    if (!seen_any) begin
      seen_any = 1'b1;
      r.first = 1'b1;
      if (seq == 16'd0) begin
        wrap_base = SEQ_STEP;
        high_seq = SEQ_STEP;
      end else begin
        high_seq = seq32;
      end
      ext = high_seq;
    end else begin
      top16 = {16'd0, high_seq[15:0]};
      if (seq32 >= top16) begin
        ext = wrap_base + seq32;
        high_seq = ext;
      end else begin
        fwd = (seq32 - top16) & 32'h0000_FFFF;
        bwd = (top16 - seq32) & 32'h0000_FFFF;
        if (fwd < bwd) begin
          wrap_base = wrap_base + SEQ_STEP;
          ext = wrap_base + seq32;
          high_seq = ext;
        end else begin
          ext = wrap_base + seq32;
        end
      end
      if (rate == 32'd0) begin
        jitter_acc = '0;
      end else begin
        dt = arr - prev_arr;
        t1 = ({32'd0, dt} * {32'd0, rate}) >> (16 - JITTER_FRAC_BITS);
        d = ts - prev_ts;
        back = prev_ts - ts;
        if (ts == prev_ts) begin
          neg = 1'b0;
          mag = 32'd0;
        end else if (ts > prev_ts) begin
          neg = (d >= TS_LIMIT);
          mag = neg ? back : d;
        end else begin
          neg = (back < TS_LIMIT);
          mag = neg ? back : d;
        end
        if (t1 > SPAN_CLAMP) t1 = SPAN_CLAMP;
        t2 = {32'd0, mag} << JITTER_FRAC_BITS;
        if (neg) begin
          absd = t1 + t2;
        end else begin
          absd = (t1 >= t2) ? (t1 - t2) : (t2 - t1);
        end
        if (absd > JIT_MAX) absd = JIT_MAX;
        acc64 = {24'd0, jitter_acc};
        if (absd >= acc64) begin
          acc64 = acc64 + ((absd - acc64) >> 4);
        end else begin
          acc64 = acc64 - (((acc64 - absd) + 64'd15) >> 4);
        end
        jitter_acc = acc64[39:0];
      end
    end
    prev_arr = arr;
    prev_ts = ts;
    jit = {24'd0, jitter_acc} >> JITTER_FRAC_BITS;
    r.ext_seq = ext;
    r.high_seq = high_seq;
    r.jitter = (jit > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : jit[31:0];
    r.count = pkt_total;
    r.sub = sub;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    pkt_stats_t want;
    pkt_stats_t got;
    if (rst) begin
      stats_q.delete();
      rate = '0;
      seen_any = 1'b0;
      high_seq = '0;
      wrap_base = '0;
      prev_arr = '0;
      prev_ts = '0;
      jitter_acc = '0;
      pkt_total = '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RATE_ADDR) begin
        rate = pwdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ext_seq = m_axis_tdata[31:0];
        got.high_seq = m_axis_tdata[63:32];
        got.jitter = m_axis_tdata[95:64];
        got.count = m_axis_tdata[127:96];
        got.first = m_axis_tuser[0];
        got.sub = m_axis_tuser[1];
        if (stats_q.size() == 0) begin
          $error("result item with none expected: extended_seq %0h", got.ext_seq);
          fail_total++;
        end else begin
          want = stats_q.pop_front();
          check_field("extended_seq", want.ext_seq, got.ext_seq);
          check_field("highest_ext_seq", want.high_seq, got.high_seq);
          check_field("jitter_units", want.jitter, got.jitter);
          check_field("packet_count", want.count, got.count);
          check_field("first_packet", {31'd0, want.first}, {31'd0, got.first});
          check_field("subflow_tag", {31'd0, want.sub}, {31'd0, got.sub});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        stats_q.push_back(predict_stats(s_axis_tdata[15:0], s_axis_tdata[47:16],
                                        s_axis_tdata[79:48], s_axis_tuser));
      end
    end
    pending <= stats_q.size();
    error_count <= fail_total;
  end

endmodule

FILE: sim/rtp_seq_extend_jitter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP sequence extension and jitter testbench
// Sends directed and random packet streams under changing rate settings and
// flow-control patterns, and reports the checker's verdict at the end.
// ----------------------------------------------------------------------------
module rtp_seq_extend_jitter_top_tb;

  localparam int JITTER_FRAC_BITS = 8;
  localparam logic [rsj_pkg::CFG_ADDR_W-1:0] RATE_ADDR = {rsj_pkg::CFG_IDX_RATE, 2'b00};
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 210;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rsj_pkg::SDATA_W-1:0]    s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [rsj_pkg::MDATA_W-1:0]    m_axis_tdata;
  logic [rsj_pkg::MUSER_W-1:0]    m_axis_tuser;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [rsj_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [rsj_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [rsj_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  int                             error_count;
  int                             pending;

  int          src_idle = 0;
  int          sink_stall = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [15:0] seq_last;
  logic [31:0] ts_last;
  logic [31:0] arr_last;

  rtp_seq_extend_jitter_top #(.JITTER_FRAC_BITS(JITTER_FRAC_BITS)) DUT (.*);

  rtp_seq_extend_jitter_checker #(.JITTER_FRAC_BITS(JITTER_FRAC_BITS)) checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  task automatic send_packet(logic [15:0] seq, logic [31:0] ts, logic [31:0] arr,
                             logic sub);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {arr, ts, seq};
    s_axis_tuser <= sub;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Mostly an in-order stream with realistic spacing, plus reordering, jumps
  // and fully random headers.
  task automatic send_random();
    int unsigned pick;
    logic [15:0] seq;
    logic [31:0] ts;
    pick = $urandom_range(99);
    arr_last = arr_last + 32'd140 + $urandom_range(40);
    if (pick < 70) begin
      seq_last = seq_last + 16'($urandom_range(1, 2));
      ts_last = ts_last + 32'd160;
      seq = seq_last;
      ts = ts_last;
    end else if (pick < 80) begin
      seq = seq_last - 16'($urandom_range(1, 30));
      ts = ts_last - $urandom_range(4800);
    end else if (pick < 90) begin
      seq_last = seq_last + 16'($urandom_range(65535));
      ts_last = ts_last + $urandom;
      arr_last = arr_last + $urandom;
      seq = seq_last;
      ts = ts_last;
    end else begin
      seq_last = 16'($urandom);
      ts_last = $urandom;
      arr_last = $urandom;
      seq = seq_last;
      ts = ts_last;
    end
    send_packet(seq, ts, arr_last, 1'($urandom));
  endtask

  task automatic write_rate(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RATE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [31:0] rate;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sequence extension cases with the jitter disabled.
    send_packet(16'h0000, 32'd0, 32'd0, 1'b0);
    send_packet(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_packet(16'h0000, 32'd100, 32'd200, 1'b0);
    send_packet(16'hFFFE, 32'd200, 32'd300, 1'b1);
    send_packet(16'h8000, 32'd300, 32'd400, 1'b0);
    send_packet(16'h0000, 32'd400, 32'd500, 1'b1);
    settle();

    // Timestamp wrap cases at one unit per tick.
    write_rate(32'h0001_0000);
    send_packet(16'h8001, 32'd1000, 32'd1000, 1'b0);
    send_packet(16'h8002, 32'd1000, 32'd1160, 1'b1);
    send_packet(16'h8003, 32'd1160, 32'd1320, 1'b0);
    send_packet(16'h8004, 32'h2000_0000, 32'd1480, 1'b1);
    send_packet(16'h8005, 32'h1FFF_FF00, 32'd1640, 1'b0);
    send_packet(16'h8006, 32'h0000_0010, 32'd1800, 1'b1);
    send_packet(16'h8007, 32'h1000_000F, 32'd1960, 1'b0);
    send_packet(16'h8008, 32'h0000_0010, 32'd2120, 1'b1);
    send_packet(16'h8009, 32'h1000_0010, 32'd2280, 1'b0);
    settle();

    // Largest rate and tick spacing drive the absolute difference into saturation.
    write_rate(32'hFFFF_FFFF);
    send_packet(16'h800A, 32'h1000_0010, 32'd0, 1'b1);
    send_packet(16'h800B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_packet(16'h800C, 32'h0000_0000, 32'hFFFF_FFFE, 1'b1);
    settle();
    write_rate(32'h0000_0001);
    send_packet(16'h800D, 32'd160, 32'd160, 1'b0);
    settle();
    write_rate(32'h0000_0000);
    send_packet(16'h800E, 32'd320, 32'd320, 1'b1);
    settle();

    seq_last = 16'h800E;
    ts_last = 32'd320;
    arr_last = 32'd320;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: rate = 32'h0001_0000;
        1: rate = 32'h0000_0001;
        2: rate = 32'hFFFF_FFFF;
        3: rate = 32'h0000_0000;
        4: rate = 32'h0000_8000;
        6: rate = 32'h0002_0000;
        default: rate = $urandom;
      endcase
      case (phase % 4)
        0: begin
          src_idle <= 0;
          sink_stall <= 0;
        end
        1: begin
          src_idle <= 56;
          sink_stall <= 0;
        end
        2: begin
          src_idle <= 0;
          sink_stall <= 56;
        end
        default: begin
          src_idle <= 16;
          sink_stall <= 16;
        end
      endcase
      write_rate(rate);
      // The sender keeps offering items while the receiver holds off.
      if (phase % 4 == 0) hold_requests <= hold_requests + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      settle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rsj_pkg.sv
rtl/core/rtp_seq_extend_jitter_top.sv
sim/rtp_seq_extend_jitter_checker.sv
sim/rtp_seq_extend_jitter_top_tb.sv
